[design/ssd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_pkg
// Shared types, codes and tables of the seven-segment display driver.
// ----------------------------------------------------------------------------
package ssd_pkg;

    localparam int DIGIT_COUNT = 8;
    localparam int ADDR_W      = 7;
    localparam int IDX_W       = 4;
    localparam logic [ADDR_W-1:0] SLAVE_ADDR_RESET = 7'h09;

    localparam logic [1:0] OP_ADDR = 2'd0;
    localparam logic [1:0] OP_DATA = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    localparam logic [3:0] CMD_INDEX   = 4'h0;
    localparam logic [3:0] CMD_DIMMER  = 4'h1;
    localparam logic [3:0] CMD_REFRESH = 4'h2;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'b001,
        MODE_WRITE = 3'b010,
        MODE_READ  = 3'b100
    } mode_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] addr;
        logic [7:0]       data;
    } wr_t;

    typedef struct packed {
        logic       refresh_en;
        logic [7:0] dimmer_mask;
    } ctrl_t;

    function automatic logic [7:0] dimmer_level(input logic [3:0] lvl);
        logic [7:0] m;
        case (lvl)
            4'd0:    m = 8'h00;
            4'd1:    m = 8'h08;
            4'd2:    m = 8'h18;
            4'd3:    m = 8'h38;
            4'd4:    m = 8'h78;
            4'd5:    m = 8'hf8;
            default: m = 8'h00;
        endcase
        return m;
    endfunction

    function automatic logic [7:0] digit_pattern(input int i);
        logic [7:0] p;
        case (i)
            0:       p = 8'h3f;
            1:       p = 8'h06;
            2:       p = 8'h5b;
            3:       p = 8'h4f;
            4:       p = 8'h66;
            5:       p = 8'h6d;
            6:       p = 8'h7d;
            7:       p = 8'h87;
            default: p = 8'h00;
        endcase
        return p;
    endfunction

endpackage

[design/i2c_seven_segment_display_driver_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_seven_segment_display_driver_top
// Eight-digit multiplexed seven-segment driver behind a byte-level bus slave.
// ----------------------------------------------------------------------------
// Each input beat is an address byte, a data byte or a refresh tick, and
// produces exactly one result beat carrying the acknowledge, the dummy read
// byte and the column and segment drive after that beat. One beat is taken
// every cycle while m_tready stays high. An accepted beat is captured in the input
// register, and when it advances the result register takes the outcome of the
// single pass of decode and scan logic, from which the result beat is presented.
// The slave address is written through cfg_we and cfg_wdata; the user must do so
// only while no beats are in flight, as the block itself does not enforce it.
module i2c_seven_segment_display_driver_top #(
    parameter int DIGIT_COUNT = ssd_pkg::DIGIT_COUNT
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [ssd_pkg::ADDR_W-1:0]  cfg_wdata,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // byte_value[7:0]
    input  logic [7:0]                  s_tdata,
    // operation[1:0]
    input  logic [1:0]                  s_tuser,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // ack, read_data, column_drive, segment_drive, refresh_on, zero fill
    output logic [((18+DIGIT_COUNT+7)/8)*8-1:0] m_tdata
);

    localparam int COL_L = 9;
    localparam int SEG_L = COL_L + DIGIT_COUNT;
    localparam int REF_B = SEG_L + 8;

    logic [ssd_pkg::ADDR_W-1:0] addr_reg;
    logic                       in_valid_reg;
    logic [1:0]                 in_op_reg;
    logic [7:0]                 in_byte_reg;
    logic                       out_valid_reg;
    logic                       res_ack_reg;
    logic [DIGIT_COUNT-1:0]     res_col_reg;
    logic [7:0]                 res_seg_reg;
    logic                       res_ref_reg;
    logic                       advance;

    logic                   ack;
    logic                   refresh_next;
    ssd_pkg::ctrl_t         ctrl;
    ssd_pkg::wr_t           wr;
    logic [DIGIT_COUNT-1:0] column_out;
    logic [7:0]             segment_out;
    logic [DIGIT_COUNT-1:0] column_next;
    logic [7:0]             segment_next;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg <= ssd_pkg::SLAVE_ADDR_RESET;
        end else if (cfg_we) begin
            addr_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_op_reg   <= s_tuser;
            in_byte_reg <= s_tdata;
        end
    end

    ssd_cmd u_cmd (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .fire          (advance),
        .op            (in_op_reg),
        .byte_in       (in_byte_reg),
        .slave_address (addr_reg),
        .ack           (ack),
        .ctrl          (ctrl),
        .refresh_next  (refresh_next),
        .wr            (wr)
    );

    ssd_scan #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_scan (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .fire         (advance),
        .tick         (in_op_reg == ssd_pkg::OP_TICK),
        .ctrl         (ctrl),
        .wr           (wr),
        .column_out   (column_out),
        .segment_out  (segment_out),
        .column_next  (column_next),
        .segment_next (segment_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_ack_reg <= ack;
            res_col_reg <= column_next;
            res_seg_reg <= segment_next;
            res_ref_reg <= refresh_next;
        end
    end

    always_comb begin
        m_tdata                    = '0;
        m_tdata[0]                 = res_ack_reg;
        m_tdata[COL_L +: DIGIT_COUNT] = res_col_reg;
        m_tdata[SEG_L +: 8]        = res_seg_reg;
        m_tdata[REF_B]             = res_ref_reg;
    end

    assign m_tvalid = out_valid_reg;

    a_tick_no_ack: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_op_reg == ssd_pkg::OP_TICK |=> !res_ack_reg)
        else $error("refresh tick produced an acknowledge");

    a_result_matches_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> res_col_reg == column_out && res_seg_reg == segment_out)
        else $error("result drive differs from scan state");

    a_column_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> $onehot0(res_col_reg))
        else $error("column drive selects more than one digit");

    a_hold_when_off: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && !ctrl.refresh_en |=> $stable(column_out) && $stable(segment_out))
        else $error("drive changed while scanning is off");

endmodule

[design/ssd_cmd.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_cmd
// Byte-level bus slave: address match, command decode and display writes.
// ----------------------------------------------------------------------------
module ssd_cmd (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         fire,
    input  logic [1:0]                   op,
    input  logic [7:0]                   byte_in,
    input  logic [ssd_pkg::ADDR_W-1:0]   slave_address,
    output logic                         ack,
    output ssd_pkg::ctrl_t               ctrl,
    output logic                         refresh_next,
    output ssd_pkg::wr_t                 wr
);

    ssd_pkg::mode_t             mode_reg, mode_next;
    logic                       first_reg, first_next;
    logic [ssd_pkg::IDX_W-1:0]  idx_reg, idx_next;
    logic [7:0]                 dim_reg, dim_next;
    logic                       ref_reg, ref_next;

    logic [3:0] cmd;
    logic [3:0] prm;

    assign cmd = byte_in[7:4];
    assign prm = byte_in[3:0];

    always_comb begin
        mode_next  = mode_reg;
        first_next = first_reg;
        idx_next   = idx_reg;
        dim_next   = dim_reg;
        ref_next   = ref_reg;
        ack        = 1'b0;
        wr.we      = 1'b0;
        wr.addr    = idx_reg;
        wr.data    = byte_in;
        case (op)
            ssd_pkg::OP_ADDR: begin
                first_next = 1'b1;
                if (byte_in == 8'h00 || byte_in[7:1] == slave_address) begin
                    ack       = 1'b1;
                    mode_next = byte_in[0] ? ssd_pkg::MODE_READ : ssd_pkg::MODE_WRITE;
                end else begin
                    mode_next = ssd_pkg::MODE_IDLE;
                end
            end
            ssd_pkg::OP_DATA: begin
                if (mode_reg == ssd_pkg::MODE_WRITE) begin
                    ack = 1'b1;
                    if (first_reg) begin
                        first_next = 1'b0;
                        case (cmd)
                            ssd_pkg::CMD_INDEX: begin
                                idx_next = prm;
                            end
                            ssd_pkg::CMD_DIMMER: begin
                                if (prm inside {[4'd0:4'd5]}) begin
                                    dim_next = ssd_pkg::dimmer_level(prm);
                                end
                            end
                            ssd_pkg::CMD_REFRESH: begin
                                ref_next = (prm == 4'd0);
                            end
                            default: begin
                            end
                        endcase
                    end else begin
                        wr.we    = 1'b1;
                        idx_next = {1'b0, idx_reg[ssd_pkg::IDX_W-2:0] + 1'b1};
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= ssd_pkg::MODE_IDLE;
            first_reg <= 1'b0;
            idx_reg   <= '0;
            dim_reg   <= 8'h00;
            ref_reg   <= 1'b1;
        end else if (fire) begin
            mode_reg  <= mode_next;
            first_reg <= first_next;
            idx_reg   <= idx_next;
            dim_reg   <= dim_next;
            ref_reg   <= ref_next;
        end
    end

    assign ctrl.refresh_en  = ref_reg;
    assign ctrl.dimmer_mask = dim_reg;
    assign refresh_next     = ref_next;

endmodule

[design/ssd_scan.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_scan
// Display memory and digit scanning with dimming and back-half overlay.
// ----------------------------------------------------------------------------
module ssd_scan #(
    parameter int DIGIT_COUNT = ssd_pkg::DIGIT_COUNT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   fire,
    input  logic                   tick,
    input  ssd_pkg::ctrl_t         ctrl,
    input  ssd_pkg::wr_t           wr,
    output logic [DIGIT_COUNT-1:0] column_out,
    output logic [7:0]             segment_out,
    output logic [DIGIT_COUNT-1:0] column_next,
    output logic [7:0]             segment_next
);

    localparam int COL_W = $clog2(DIGIT_COUNT);

    logic [7:0]             front_reg [DIGIT_COUNT];
    logic [7:0]             back_reg  [DIGIT_COUNT];
    logic [7:0]             frame_reg, frame_next;
    logic [2:0]             blink_reg, blink_next;
    logic [DIGIT_COUNT-1:0] col_reg;
    logic [7:0]             seg_reg;
    logic [COL_W-1:0]       col;
    logic                   step;

    assign col  = frame_reg[COL_W-1:0];
    assign step = tick && ctrl.refresh_en;

    always_comb begin
        column_next  = col_reg;
        segment_next = seg_reg;
        frame_next   = frame_reg;
        blink_next   = blink_reg;
        if (step) begin
            column_next = '0;
            column_next[col] = 1'b1;
            if ((frame_reg & ctrl.dimmer_mask) != 8'h00) begin
                segment_next = 8'h00;
            end else if (blink_reg == 3'd0) begin
                segment_next = front_reg[col] | back_reg[col];
            end else begin
                segment_next = front_reg[col];
            end
            frame_next = frame_reg + 8'd1;
            if (frame_next[COL_W-1:0] == '0) begin
                blink_next = blink_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DIGIT_COUNT; i++) begin
                front_reg[i] <= ssd_pkg::digit_pattern(i);
                back_reg[i]  <= 8'h00;
            end
            frame_reg <= 8'h00;
            blink_reg <= 3'd0;
            col_reg   <= '0;
            seg_reg   <= 8'h00;
        end else if (fire) begin
            if (wr.we) begin
                if (wr.addr[COL_W]) begin
                    back_reg[wr.addr[COL_W-1:0]] <= wr.data;
                end else begin
                    front_reg[wr.addr[COL_W-1:0]] <= wr.data;
                end
            end
            frame_reg <= frame_next;
            blink_reg <= blink_next;
            col_reg   <= column_next;
            seg_reg   <= segment_next;
        end
    end

    assign column_out  = col_reg;
    assign segment_out = seg_reg;

endmodule
